// ----- hdl/mthd_pkg.sv -----
// shared types and constants of the multibit trie huffman decoder
package mthd_pkg;

   localparam int WINDOW_BITS = 32;
   localparam int LEN_W       = 6;
   localparam int SYM_OUT_W   = 16;

   typedef enum logic {
      FUNC_ADD    = 1'b0,
      FUNC_DECODE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_COLLISION = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // kind code held in the top two bits of a child slot
   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_NODE  = 2'd1,
      KIND_LEAF  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_LVL,
      S_ADD_CHK,
      S_FIN_CHK,
      S_FIN_WR,
      S_DEC_LVL,
      S_DEC_CHK,
      S_LEAF_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic is_add;
   } walk_ctl_type;

   typedef struct packed {
      logic last_level;
      logic window_end;
   } walk_stat_type;

endpackage

// ----- hdl/mthd_if.sv -----
// request and response channel interfaces of the multibit trie huffman decoder
interface mthd_req_if import mthd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   func_type               func;
   logic [WINDOW_BITS-1:0] code_bits;
   logic [LEN_W-1:0]       code_length;
   logic [SYM_OUT_W-1:0]   symbol;

   modport source (output valid, func, code_bits, code_length, symbol, input ready);
   modport sink   (input valid, func, code_bits, code_length, symbol, output ready);
endinterface

interface mthd_rsp_if import mthd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [SYM_OUT_W-1:0] decoded_symbol;
   logic [LEN_W-1:0]     consumed_length;

   modport source (output valid, status, decoded_symbol, consumed_length, input ready);
   modport sink   (input valid, status, decoded_symbol, consumed_length, output ready);
endinterface

// ----- hdl/mthd_ram.sv -----
// generic single write port ram with registered read
module mthd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mthd_walk.sv -----
// digit walker: shared shifter that aligns the code or window and steps one digit a level
module mthd_walk import mthd_pkg::*; #(
   parameter int LG2 = 2
) (
   input  logic                   clock,
   input  walk_ctl_type           ctl,
   input  logic [WINDOW_BITS-1:0] load_bits,
   input  logic [LEN_W-1:0]       load_len,
   output logic [LG2-1:0]         digit,
   output logic [LG2-1:0]         digit_next,
   output logic [LG2-1:0]         pad_mask,
   output walk_stat_type          stat
);

   logic [WINDOW_BITS-1:0] walk_ff, walk_in;
   logic [LEN_W-1:0]       pos_ff, pos_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [WINDOW_BITS-1:0] sh_src, sh_out;
   logic [LEN_W-1:0]       sh_amt;
   logic [LEN_W-1:0]       rem;
   logic [LEN_W-1:0]       pad;
   logic [LEN_W:0]         pos_sum;

   // the one shifter: left-aligns an add code on load, drops a digit on step
   always_comb begin
      sh_src = ctl.load ? load_bits : walk_ff;
      if (ctl.load) begin
         sh_amt = ctl.is_add ? (LEN_W'(WINDOW_BITS) - load_len) : '0;
      end else begin
         sh_amt = LEN_W'(LG2);
      end
      sh_out = sh_src << sh_amt;
   end

   always_comb begin
      walk_in = (ctl.load || ctl.step) ? sh_out : walk_ff;
      pos_in  = ctl.load ? '0 : (ctl.step ? pos_ff + LEN_W'(LG2) : pos_ff);
      len_in  = ctl.load ? load_len : len_ff;
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      pos_ff  <= pos_in;
      len_ff  <= len_in;
   end

   always_comb begin
      rem     = len_ff - pos_ff;
      pad     = LEN_W'(LG2) - rem;
      pos_sum = {1'b0, pos_ff} + (LEN_W + 1)'(LG2);
      for (int i = 0; i < LG2; i++) begin
         pad_mask[i] = (LEN_W'(i) < pad);
      end
      stat.last_level = (rem <= LEN_W'(LG2));
      stat.window_end = (pos_sum >= (LEN_W + 1)'(WINDOW_BITS));
   end

   assign digit      = walk_ff[WINDOW_BITS-1 -: LG2];
   assign digit_next = walk_ff[WINDOW_BITS-1-LG2 -: LG2];

endmodule

// ----- hdl/multibit_trie_huffman_decoder.sv -----
// top level of the multibit trie huffman decoder: sequencer, trie tables and response register
//
// Huffman code table kept as a trie with 2^LG2 child slots per node, LG2 being the smallest k of
// 1 to 4 with 2^k >= RADIX, or 4 if none. A transaction with func = add inserts a right-aligned
// code of 1 to 32 bits and its symbol; a transaction with func = decode walks a 32-bit MSB-first
// window and returns the symbol and the code length to advance the stream by. Status reports ok,
// not found (also a bad add length), collision or pool full; nodes made by a failed add stay in
// place. One transaction is worked at a time and req ready is low meanwhile. After reset the
// child table is swept empty, one slot per cycle, over all MAX_NODES * 2^LG2 slots, before the
// first transaction is taken. A decode reads the child table once per trie level walked (at
// most ceil(32 / LG2) levels) and, when it finds a leaf, then reads the leaf table. An add
// reads and checks the slot of each interior level; at the last digit it checks every slot
// that the padding bits of that digit cover and then writes the leaf into each of them. The
// response sits in an output register, so a new transaction is taken while the last response
// waits.
module multibit_trie_huffman_decoder import mthd_pkg::*; #(
   parameter int RADIX       = 4,
   parameter int MAX_NODES   = 256,
   parameter int MAX_LEAVES  = 256,
   parameter int SYMBOL_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mthd_req_if.sink   req_ch,
   mthd_rsp_if.source rsp_ch
);

   // trie geometry
   localparam int LG2     = (RADIX > 8) ? 4 : (RADIX > 4) ? 3 : (RADIX > 2) ? 2 : 1;
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int LEAF_W  = $clog2(MAX_LEAVES);
   localparam int IDX_W   = (NODE_W > LEAF_W) ? NODE_W : LEAF_W;
   localparam int CADDR_W = NODE_W + LG2;
   localparam int CDEPTH  = MAX_NODES * (1 << LG2);
   localparam int CENT_W  = 2 + IDX_W;
   localparam int NCNT_W  = $clog2(MAX_NODES + 1);
   localparam int LCNT_W  = $clog2(MAX_LEAVES + 1);
   localparam int SYM_W   = (SYMBOL_BITS < SYM_OUT_W) ? SYMBOL_BITS : SYM_OUT_W;
   localparam int LENT_W  = LEN_W + SYM_W;

   // sequencer state
   state_type             state_ff, state_in;
   logic [NODE_W-1:0]     node_ff, node_in;
   logic [LG2-1:0]        slot_ff, slot_in;
   logic [NCNT_W-1:0]     nodes_used_ff, nodes_used_in;
   logic [LCNT_W-1:0]     leaves_used_ff, leaves_used_in;
   logic [CADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [LENT_W-1:0]     leaf_wdata_ff, leaf_wdata_in;

   // result staging and output register
   status_type            res_status_ff, res_status_in;
   logic [SYM_OUT_W-1:0]  res_sym_ff, res_sym_in;
   logic [LEN_W-1:0]      res_len_ff, res_len_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SYM_OUT_W-1:0]  rsp_sym_ff, rsp_sym_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;

   // child table port
   logic                  c_wr_en;
   logic [CADDR_W-1:0]    c_wr_addr;
   logic [CENT_W-1:0]     c_wr_data;
   logic [CADDR_W-1:0]    c_rd_addr;
   logic [CENT_W-1:0]     c_rd_data;
   kind_type              c_rd_kind;
   logic [IDX_W-1:0]      c_rd_idx;

   // leaf table port
   logic                  l_wr_en;
   logic [LEAF_W-1:0]     l_rd_addr;
   logic [LENT_W-1:0]     l_rd_data;

   // walker
   walk_ctl_type          walk_ctl;
   walk_stat_type         walk_stat;
   logic [LG2-1:0]        digit;
   logic [LG2-1:0]        digit_next;
   logic [LG2-1:0]        pad_mask;

   logic                  accept;
   logic                  rsp_free;
   logic                  slot_last;
   logic                  bad_len;

   mthd_walk #(
      .LG2 (LG2)
   ) u_walk (
      .clock      (clock),
      .ctl        (walk_ctl),
      .load_bits  (req_ch.code_bits),
      .load_len   (req_ch.code_length),
      .digit      (digit),
      .digit_next (digit_next),
      .pad_mask   (pad_mask),
      .stat       (walk_stat)
   );

   mthd_ram #(
      .WIDTH (CENT_W),
      .DEPTH (CDEPTH)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   // leaf entry: code length above, symbol below
   mthd_ram #(
      .WIDTH (LENT_W),
      .DEPTH (MAX_LEAVES)
   ) u_leaf_ram (
      .clock   (clock),
      .wr_en   (l_wr_en),
      .wr_addr (leaves_used_ff[LEAF_W-1:0]),
      .wr_data (leaf_wdata_ff),
      .rd_addr (l_rd_addr),
      .rd_data (l_rd_data)
   );

   assign c_rd_kind = kind_type'(c_rd_data[IDX_W +: 2]);
   assign c_rd_idx  = c_rd_data[IDX_W-1:0];
   assign l_rd_addr = c_rd_idx[LEAF_W-1:0];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   // last slot of the range that the padding of the final digit covers
   assign slot_last    = &(slot_ff | ~pad_mask);
   assign bad_len      = (req_ch.code_length == '0) ||
                         (req_ch.code_length > LEN_W'(WINDOW_BITS));

   always_comb begin
      state_in       = state_ff;
      node_in        = node_ff;
      slot_in        = slot_ff;
      nodes_used_in  = nodes_used_ff;
      leaves_used_in = leaves_used_ff;
      clr_cnt_in     = clr_cnt_ff;
      leaf_wdata_in  = leaf_wdata_ff;
      res_status_in  = res_status_ff;
      res_sym_in     = res_sym_ff;
      res_len_in     = res_len_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_sym_in     = rsp_sym_ff;
      rsp_len_in     = rsp_len_ff;

      walk_ctl.load   = 1'b0;
      walk_ctl.step   = 1'b0;
      walk_ctl.is_add = (req_ch.func == FUNC_ADD);

      c_wr_en   = 1'b0;
      c_wr_addr = {node_ff, slot_ff};
      c_wr_data = {KIND_LEAF, IDX_W'(leaves_used_ff[LEAF_W-1:0])};
      c_rd_addr = {node_ff, digit};
      l_wr_en   = 1'b0;

      case (state_ff)
         // sweep the child table empty after reset
         S_CLEAR: begin
            c_wr_en   = 1'b1;
            c_wr_addr = clr_cnt_ff;
            c_wr_data = '0;
            if (clr_cnt_ff == CADDR_W'(CDEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (accept) begin
               walk_ctl.load = 1'b1;
               node_in       = '0;
               leaf_wdata_in = {req_ch.code_length, req_ch.symbol[SYM_W-1:0]};
               res_sym_in    = '0;
               res_len_in    = '0;
               if (req_ch.func == FUNC_DECODE) begin
                  state_in = S_DEC_LVL;
               end else if (bad_len) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_ADD_LVL;
               end
            end
         end

         // add: read the slot of this digit; the last digit goes to the range check
         S_ADD_LVL: begin
            if (walk_stat.last_level) begin
               slot_in  = digit;
               state_in = S_FIN_CHK;
            end else begin
               state_in = S_ADD_CHK;
            end
         end

         S_ADD_CHK: begin
            case (c_rd_kind)
               KIND_NODE: begin
                  node_in       = c_rd_idx[NODE_W-1:0];
                  walk_ctl.step = 1'b1;
                  state_in      = S_ADD_LVL;
               end
               KIND_EMPTY: begin
                  if (nodes_used_ff >= NCNT_W'(MAX_NODES)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     // new subtree node; its slots are still empty from the sweep
                     c_wr_en       = 1'b1;
                     c_wr_addr     = {node_ff, digit};
                     c_wr_data     = {KIND_NODE, IDX_W'(nodes_used_ff[NODE_W-1:0])};
                     node_in       = nodes_used_ff[NODE_W-1:0];
                     nodes_used_in = nodes_used_ff + 1'b1;
                     walk_ctl.step = 1'b1;
                     state_in      = S_ADD_LVL;
                  end
               end
               default: begin
                  res_status_in = ST_COLLISION;
                  state_in      = S_DONE;
               end
            endcase
         end

         // every padded slot of the last digit must be empty
         S_FIN_CHK: begin
            if (c_rd_kind != KIND_EMPTY) begin
               res_status_in = ST_COLLISION;
               state_in      = S_DONE;
            end else if (slot_last) begin
               if (leaves_used_ff >= LCNT_W'(MAX_LEAVES)) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  l_wr_en  = 1'b1;
                  slot_in  = digit;
                  state_in = S_FIN_WR;
               end
            end else begin
               slot_in   = slot_ff + 1'b1;
               c_rd_addr = {node_ff, slot_ff + 1'b1};
            end
         end

         // replicate the leaf over the padded slots
         S_FIN_WR: begin
            c_wr_en = 1'b1;
            if (slot_last) begin
               leaves_used_in = leaves_used_ff + 1'b1;
               res_status_in  = ST_OK;
               state_in       = S_DONE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end

         S_DEC_LVL: begin
            state_in = S_DEC_CHK;
         end

         // decode: one level a cycle, next read issued straight from the slot just read
         S_DEC_CHK: begin
            case (c_rd_kind)
               KIND_LEAF: begin
                  state_in = S_LEAF_CHK;
               end
               KIND_NODE: begin
                  if (walk_stat.window_end) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     node_in       = c_rd_idx[NODE_W-1:0];
                     walk_ctl.step = 1'b1;
                     c_rd_addr     = {c_rd_idx[NODE_W-1:0], digit_next};
                  end
               end
               default: begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end
            endcase
         end

         S_LEAF_CHK: begin
            res_status_in = ST_OK;
            res_sym_in    = SYM_OUT_W'(l_rd_data[SYM_W-1:0]);
            res_len_in    = l_rd_data[LENT_W-1 -: LEN_W];
            state_in      = S_DONE;
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sym_in    = res_sym_ff;
               rsp_len_in    = res_len_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         nodes_used_ff  <= NCNT_W'(1);
         leaves_used_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         nodes_used_ff  <= nodes_used_in;
         leaves_used_ff <= leaves_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      slot_ff       <= slot_in;
      leaf_wdata_ff <= leaf_wdata_in;
      res_status_ff <= res_status_in;
      res_sym_ff    <= res_sym_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.decoded_symbol  = rsp_sym_ff;
   assign rsp_ch.consumed_length = rsp_len_ff;

   // node pool count stays within root only and full
   a_nodes_range: assert property (@(posedge clock) disable iff (reset)
      (nodes_used_ff >= NCNT_W'(1)) && (nodes_used_ff <= NCNT_W'(MAX_NODES)))
      else $error("node pool count out of range");

   // the leaf count moves only at the end of a leaf replication
   a_leaf_count: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (leaves_used_ff != $past(leaves_used_ff)))
      |-> ($past(state_ff) == S_FIN_WR))
      else $error("leaf count changed outside leaf write");

   // a decode walk never writes the child table
   a_decode_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DEC_LVL) || (state_ff == S_DEC_CHK) || (state_ff == S_LEAF_CHK))
      |-> !c_wr_en)
      else $error("child table written during decode");

endmodule
